>>> rtl/ccvs_pkg.sv
package ccvs_pkg;

  // Field and register widths
  localparam int DIST_W        = 24;
  localparam int CFG_W         = 24;
  localparam int CFG_IDX_W     = 2;
  localparam int ANGLE_BITS    = 16;
  localparam int OUT_FRAC_BITS = 16;
  localparam int WEIGHT_W      = OUT_FRAC_BITS + 1;
  localparam int SLOPE_W       = OUT_FRAC_BITS + 10;
  localparam int OUT_DATA_W    = ((WEIGHT_W + SLOPE_W + 7) / 8) * 8;

  // Angle product: fraction of a quarter turn times pi in Q30
  localparam int XP_W = ANGLE_BITS + 31;
  // pi * inverse width in Q30
  localparam int K_W  = 40;

  // Register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE = 2'd2;

  localparam logic [CFG_W-1:0] CUTOFF_RST  = 24'd1310720;
  localparam logic [CFG_W-1:0] WIDTH_RST   = 24'd262144;
  localparam logic [CFG_W-1:0] INVERSE_RST = 24'd65536;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  // Series terms, one per cell
  localparam int N_TERMS = 11;

  typedef logic [31:0]        term_t;
  typedef logic signed [33:0] sum_t;

  typedef enum logic [1:0] {
    REGION_BAND    = 2'd0,
    REGION_INSIDE  = 2'd1,
    REGION_OUTSIDE = 2'd2
  } region_t;

  // Sideband that travels with every item down the pipeline
  typedef struct packed {
    logic       valid;
    region_t    region;
    logic [1:0] quad;
  } ctrl_t;

  // Per-cell constants: sign of the term and the two divisors with reciprocals
  typedef struct packed {
    logic        sub;
    logic [8:0]  div_sin;
    logic [31:0] rcp_sin;
    logic [8:0]  div_cos;
    logic [31:0] rcp_cos;
  } cell_cfg_t;

  // Reciprocals are floor((2^33 - 1) / divisor); quotient is off by at most one
  localparam logic [63:0] RECIP_NUM = 64'h1_FFFF_FFFF;

  localparam logic [8:0] DIV_SIN [N_TERMS] = '{
    9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342, 9'd420, 9'd506
  };
  localparam logic [8:0] DIV_COS [N_TERMS] = '{
    9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306, 9'd380, 9'd462
  };
  localparam logic [31:0] RCP_SIN [N_TERMS] = '{
    32'(RECIP_NUM / 64'd6),   32'(RECIP_NUM / 64'd20),  32'(RECIP_NUM / 64'd42),
    32'(RECIP_NUM / 64'd72),  32'(RECIP_NUM / 64'd110), 32'(RECIP_NUM / 64'd156),
    32'(RECIP_NUM / 64'd210), 32'(RECIP_NUM / 64'd272), 32'(RECIP_NUM / 64'd342),
    32'(RECIP_NUM / 64'd420), 32'(RECIP_NUM / 64'd506)
  };
  localparam logic [31:0] RCP_COS [N_TERMS] = '{
    32'(RECIP_NUM / 64'd2),   32'(RECIP_NUM / 64'd12),  32'(RECIP_NUM / 64'd30),
    32'(RECIP_NUM / 64'd56),  32'(RECIP_NUM / 64'd90),  32'(RECIP_NUM / 64'd132),
    32'(RECIP_NUM / 64'd182), 32'(RECIP_NUM / 64'd240), 32'(RECIP_NUM / 64'd306),
    32'(RECIP_NUM / 64'd380), 32'(RECIP_NUM / 64'd462)
  };

  function automatic cell_cfg_t cell_cfg(input int idx);
    cell_cfg_t c;
    c.sub     = idx[0];
    c.div_sin = DIV_SIN[idx];
    c.rcp_sin = RCP_SIN[idx];
    c.div_cos = DIV_COS[idx];
    c.rcp_cos = RCP_COS[idx];
    return c;
  endfunction

endpackage

>>> rtl/ccvs_front.sv
module ccvs_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_fire,
  input  logic [ccvs_pkg::DIST_W-1:0]  distance,
  input  logic [ccvs_pkg::CFG_W-1:0]   cutoff_distance,
  input  logic [ccvs_pkg::CFG_W-1:0]   transition_width,
  input  logic [ccvs_pkg::CFG_W-1:0]   inverse_width,
  output ccvs_pkg::ctrl_t              ctrl_out,
  output ccvs_pkg::term_t              x_out,
  output ccvs_pkg::term_t              x2_out
);
  import ccvs_pkg::*;

  logic signed [DIST_W+1:0] inner;
  logic signed [DIST_W+1:0] r_s;
  logic signed [DIST_W+1:0] d_full;
  region_t                  region;

  ctrl_t                    ctrl0, ctrl1, ctrl2, ctrl3;
  logic [DIST_W-1:0]        d0;
  logic [2*CFG_W-1:0]       prod;
  logic [2*CFG_W:0]         rnd;
  logic [ANGLE_BITS:0]      p1;
  logic [XP_W-1:0]          xp;
  logic [30:0]              x2r, x3;
  logic [61:0]              x2p;
  logic [31:0]              x2_3;

  // Classify the distance against the band
  always_comb begin
    inner  = $signed({2'b00, cutoff_distance}) - $signed({2'b00, transition_width});
    r_s    = $signed({2'b00, distance});
    d_full = r_s - inner;
    if (r_s <= inner) begin
      region = REGION_INSIDE;
    end else if (distance >= cutoff_distance) begin
      region = REGION_OUTSIDE;
    end else begin
      region = REGION_BAND;
    end
  end

  // Phase product with round half up to the angle grid
  always_comb begin
    prod = {{CFG_W{1'b0}}, d0} * {{DIST_W{1'b0}}, inverse_width};
    rnd  = {1'b0, prod} + ((2*CFG_W+1)'(1) << (33 - ANGLE_BITS));
  end

  // Rest angle in Q30 radians
  always_comb begin
    xp = XP_W'(p1[ANGLE_BITS-2:0]) * XP_W'(PI_Q30);
  end

  // Square of the rest angle
  always_comb begin
    x2p = {31'b0, x2r} * {31'b0, x2r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl0 <= '0;
      ctrl1 <= '0;
      ctrl2 <= '0;
      ctrl3 <= '0;
    end else if (en) begin
      ctrl0 <= '{valid: in_fire, region: region, quad: 2'b00};
      ctrl1 <= ctrl0;
      ctrl2 <= '{valid: ctrl1.valid, region: ctrl1.region,
                 quad: p1[ANGLE_BITS:ANGLE_BITS-1]};
      ctrl3 <= ctrl2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0   <= d_full[DIST_W-1:0];
      p1   <= rnd[34-ANGLE_BITS +: ANGLE_BITS+1];
      x2r  <= xp[ANGLE_BITS +: 31];
      x3   <= x2r;
      x2_3 <= x2p[61:30];
    end
  end

  assign ctrl_out = ctrl3;
  assign x_out    = {1'b0, x3};
  assign x2_out   = x2_3;

endmodule

>>> rtl/ccvs_cell.sv
module ccvs_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  ccvs_pkg::cell_cfg_t cfg,
  input  ccvs_pkg::ctrl_t     ctrl_in,
  input  ccvs_pkg::term_t     ts_in,
  input  ccvs_pkg::term_t     tc_in,
  input  ccvs_pkg::term_t     x2_in,
  input  ccvs_pkg::sum_t      ss_in,
  input  ccvs_pkg::sum_t      cs_in,
  output ccvs_pkg::ctrl_t     ctrl_out,
  output ccvs_pkg::term_t     ts_out,
  output ccvs_pkg::term_t     tc_out,
  output ccvs_pkg::term_t     x2_out,
  output ccvs_pkg::sum_t      ss_out,
  output ccvs_pkg::sum_t      cs_out
);
  import ccvs_pkg::*;

  // Stage 1: accumulate this term, multiply it by x^2
  ctrl_t       ctrl1;
  sum_t        ss1, cs1;
  term_t       x2_1;
  logic [63:0] ps1, pc1;

  // Stage 2: estimate the quotient by reciprocal
  ctrl_t       ctrl2;
  sum_t        ss2, cs2;
  term_t       x2_2;
  logic [32:0] as2, ac2;
  logic [31:0] qs2, qc2;
  logic [64:0] rs_prod, rc_prod;

  // Stage 3: correct the quotient by one
  ctrl_t       ctrl3;
  sum_t        ss3, cs3;
  term_t       x2_3, ts3, tc3;
  logic [40:0] qd_s, qd_c;
  logic [32:0] rem_s, rem_c;

  sum_t        ts_ext, tc_ext;

  always_comb begin
    ts_ext = $signed({2'b00, ts_in});
    tc_ext = $signed({2'b00, tc_in});
  end

  always_comb begin
    rs_prod = {32'b0, ps1[62:30]} * {33'b0, cfg.rcp_sin};
    rc_prod = {32'b0, pc1[62:30]} * {33'b0, cfg.rcp_cos};
  end

  always_comb begin
    qd_s  = {9'b0, qs2} * {32'b0, cfg.div_sin};
    qd_c  = {9'b0, qc2} * {32'b0, cfg.div_cos};
    rem_s = as2 - qd_s[32:0];
    rem_c = ac2 - qd_c[32:0];
  end

  // Advance the valid sideband
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1 <= '0;
      ctrl2 <= '0;
      ctrl3 <= '0;
    end else if (en) begin
      ctrl1 <= ctrl_in;
      ctrl2 <= ctrl1;
      ctrl3 <= ctrl2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ss1  <= cfg.sub ? ss_in - ts_ext : ss_in + ts_ext;
      cs1  <= cfg.sub ? cs_in - tc_ext : cs_in + tc_ext;
      x2_1 <= x2_in;
      ps1  <= {32'b0, ts_in} * {32'b0, x2_in};
      pc1  <= {32'b0, tc_in} * {32'b0, x2_in};

      ss2  <= ss1;
      cs2  <= cs1;
      x2_2 <= x2_1;
      as2  <= ps1[62:30];
      ac2  <= pc1[62:30];
      qs2  <= rs_prod[64:33];
      qc2  <= rc_prod[64:33];

      ss3  <= ss2;
      cs3  <= cs2;
      x2_3 <= x2_2;
      ts3  <= qs2 + 32'(rem_s >= {24'b0, cfg.div_sin});
      tc3  <= qc2 + 32'(rem_c >= {24'b0, cfg.div_cos});
    end
  end

  assign ctrl_out = ctrl3;
  assign ts_out   = ts3;
  assign tc_out   = tc3;
  assign x2_out   = x2_3;
  assign ss_out   = ss3;
  assign cs_out   = cs3;

endmodule

>>> rtl/ccvs_back.sv
module ccvs_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  ccvs_pkg::ctrl_t                     ctrl_in,
  input  ccvs_pkg::sum_t                      ss_in,
  input  ccvs_pkg::sum_t                      cs_in,
  input  logic [ccvs_pkg::K_W-1:0]            k,
  output logic                                out_valid,
  output logic [ccvs_pkg::WEIGHT_W-1:0]       weight,
  output logic signed [ccvs_pkg::SLOPE_W-1:0] slope
);
  import ccvs_pkg::*;

  localparam sum_t SUM_ONE = 34'sd1073741824;
  localparam logic [SLOPE_W:0]   MAG_CAP = {2'b01, {(SLOPE_W-1){1'b0}}};
  localparam logic [SLOPE_W-1:0] SMAX    = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] W_ONE  = {1'b1, {OUT_FRAC_BITS{1'b0}}};

  sum_t               ss_c, cs_c;
  logic signed [31:0] s0, c0, sn, cn;
  logic [31:0]        wsum;
  logic [30:0]        smag, srnd;

  ctrl_t               ctrl1, ctrl2;
  logic [WEIGHT_W-1:0] w1, w2;
  logic [24:0]         s24;
  logic                neg1, neg2;
  logic [44:0]         ph, pl;

  logic [65:0]         total;
  logic [SLOPE_W:0]    m_full;
  logic [SLOPE_W-1:0]  mag;
  logic [SLOPE_W-1:0]  sv;
  logic [WEIGHT_W-1:0] w_sel;
  logic [SLOPE_W-1:0]  s_sel;

  // Clamp the sums and rotate by the quadrant
  always_comb begin
    ss_c = (ss_in > SUM_ONE) ? SUM_ONE : ((ss_in < -SUM_ONE) ? -SUM_ONE : ss_in);
    cs_c = (cs_in > SUM_ONE) ? SUM_ONE : ((cs_in < -SUM_ONE) ? -SUM_ONE : cs_in);
    s0   = ss_c[31:0];
    c0   = cs_c[31:0];
    case (ctrl_in.quad)
      2'd0: begin
        sn = s0;
        cn = c0;
      end
      2'd1: begin
        sn = c0;
        cn = -s0;
      end
      2'd2: begin
        sn = -s0;
        cn = -c0;
      end
      2'd3: begin
        sn = -c0;
        cn = s0;
      end
      default: begin
        sn = s0;
        cn = c0;
      end
    endcase
    wsum = $unsigned(cn) + ONE_Q30 + (32'd1 << (30 - OUT_FRAC_BITS));
    smag = sn[31] ? 31'(-sn) : 31'(sn);
    srnd = smag + 31'd32;
  end

  // Round the magnitude and saturate the slope
  always_comb begin
    total  = {1'b0, ph, 20'b0} + {21'b0, pl} + (66'd1 << (54 - OUT_FRAC_BITS));
    m_full = total[65:55-OUT_FRAC_BITS];
    mag    = (m_full > MAG_CAP) ? MAG_CAP[SLOPE_W-1:0] : m_full[SLOPE_W-1:0];
    if (neg2) begin
      sv = (mag > SMAX) ? SMAX : mag;
    end else begin
      sv = -mag;
    end
  end

  // Pick the result by region
  always_comb begin
    case (ctrl2.region)
      REGION_INSIDE: begin
        w_sel = W_ONE;
        s_sel = '0;
      end
      REGION_OUTSIDE: begin
        w_sel = '0;
        s_sel = '0;
      end
      REGION_BAND: begin
        w_sel = w2;
        s_sel = sv;
      end
      default: begin
        w_sel = '0;
        s_sel = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1     <= '0;
      ctrl2     <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      ctrl1     <= ctrl_in;
      ctrl2     <= ctrl1;
      out_valid <= ctrl2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1     <= wsum[31-OUT_FRAC_BITS +: WEIGHT_W];
      s24    <= srnd[30:6];
      neg1   <= sn[31];
      w2     <= w1;
      neg2   <= neg1;
      ph     <= {25'b0, k[K_W-1:20]} * {20'b0, s24};
      pl     <= {25'b0, k[19:0]} * {20'b0, s24};
      weight <= w_sel;
      slope  <= s_sel;
    end
  end

endmodule

>>> rtl/cosine_cutoff_value_and_slope_core.sv
// Cosine cutoff weight and slope for one pair distance.
//
// Input stream (s_*): one distance per transfer, unsigned Q6.18.
// Output stream (m_*): weight (Q1.16, 65536 is one) and slope (signed Q10.16,
// derivative with respect to distance), one result per input, in order.
// Registers (cfg_*): cutoff distance, transition width and inverse width,
// written at any edge with cfg_wen high; change them only while no item is
// in flight.
//
// Throughput is one item per cycle while the output is not stalled. From input
// transfer to m_tvalid an item passes 4 front stages (classify, phase multiply,
// angle multiply, square), 11 series cells of 3 stages each (multiply by x^2,
// reciprocal estimate, correction), and 3 back stages (rotate, slope partial
// products, round and select into the output register).
// When the output register holds a result that is not taken, the whole
// pipeline holds and s_tready drops; otherwise an item enters every cycle.
// Reset loads the register defaults (5.0, 1.0, 1.0) and clears all valid
// bits; the block takes items on the first cycle after reset.
module cosine_cutoff_value_and_slope_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [ccvs_pkg::DIST_W-1:0]           s_tdata,   // [23:0] distance
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [ccvs_pkg::OUT_DATA_W-1:0]       m_tdata,   // [16:0] weight, [42:17] slope
  input  logic                                  cfg_wen,
  input  logic [ccvs_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [ccvs_pkg::CFG_W-1:0]            cfg_wdata
);
  import ccvs_pkg::*;

  logic [CFG_W-1:0]   cutoff_distance;
  logic [CFG_W-1:0]   transition_width;
  logic [CFG_W-1:0]   inverse_width;
  logic [K_W-1:0]     k;
  logic [55:0]        k_prod;
  logic               en;

  ctrl_t              ch_ctrl [N_TERMS+1];
  term_t              ch_ts   [N_TERMS+1];
  term_t              ch_tc   [N_TERMS+1];
  term_t              ch_x2   [N_TERMS+1];
  sum_t               ch_ss   [N_TERMS+1];
  sum_t               ch_cs   [N_TERMS+1];

  logic [WEIGHT_W-1:0]       weight;
  logic signed [SLOPE_W-1:0] slope;

  // Hold the whole pipeline while a result waits at the output
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_distance  <= CUTOFF_RST;
      transition_width <= WIDTH_RST;
      inverse_width    <= INVERSE_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        CFG_CUTOFF:  cutoff_distance  <= cfg_wdata;
        CFG_WIDTH:   transition_width <= cfg_wdata;
        CFG_INVERSE: inverse_width    <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // pi times the inverse width in Q30, settled long before any item needs it
  assign k_prod = {32'b0, inverse_width} * {24'b0, PI_Q30};

  always_ff @(posedge clk) begin
    k <= k_prod[55:16];
  end

  ccvs_front u_front (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_fire          (s_tvalid),
    .distance         (s_tdata),
    .cutoff_distance  (cutoff_distance),
    .transition_width (transition_width),
    .inverse_width    (inverse_width),
    .ctrl_out         (ch_ctrl[0]),
    .x_out            (ch_ts[0]),
    .x2_out           (ch_x2[0])
  );

  assign ch_tc[0] = ONE_Q30;
  assign ch_ss[0] = '0;
  assign ch_cs[0] = '0;

  // Taylor series, one term per cell
  for (genvar i = 0; i < N_TERMS; i++) begin : g_cell
    ccvs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .cfg      (cell_cfg(i)),
      .ctrl_in  (ch_ctrl[i]),
      .ts_in    (ch_ts[i]),
      .tc_in    (ch_tc[i]),
      .x2_in    (ch_x2[i]),
      .ss_in    (ch_ss[i]),
      .cs_in    (ch_cs[i]),
      .ctrl_out (ch_ctrl[i+1]),
      .ts_out   (ch_ts[i+1]),
      .tc_out   (ch_tc[i+1]),
      .x2_out   (ch_x2[i+1]),
      .ss_out   (ch_ss[i+1]),
      .cs_out   (ch_cs[i+1])
    );
  end

  ccvs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ctrl_in   (ch_ctrl[N_TERMS]),
    .ss_in     (ch_ss[N_TERMS]),
    .cs_in     (ch_cs[N_TERMS]),
    .k         (k),
    .out_valid (m_tvalid),
    .weight    (weight),
    .slope     (slope)
  );

  assign m_tdata = {{(OUT_DATA_W-WEIGHT_W-SLOPE_W){1'b0}}, slope, weight};

`ifndef SYNTHESIS
  // Terms past the last cell fall below one LSB of Q30
  a_series_tail: assert property (@(posedge clk) disable iff (rst)
    ch_ctrl[N_TERMS].valid |-> (ch_ts[N_TERMS] == '0) && (ch_tc[N_TERMS] == '0))
    else $error("series tail not negligible");

  // x^2 stays below 2.5 in Q30, a bound just above (pi/2)^2
  a_x2_range: assert property (@(posedge clk) disable iff (rst)
    ch_ctrl[N_TERMS].valid |-> ch_x2[N_TERMS] < 32'hA000_0000)
    else $error("angle square out of range");

  // Weight never exceeds one
  a_weight_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[WEIGHT_W-1:0] <= {1'b1, {OUT_FRAC_BITS{1'b0}}})
    else $error("weight above one");

  // A stall freezes the series chain
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> ch_ctrl[N_TERMS].valid == $past(ch_ctrl[N_TERMS].valid))
    else $error("chain moved during stall");
`endif

endmodule

>>> verif/cosine_cutoff_value_and_slope_core_tb.sv
`timescale 1ns / 100ps

module cosine_cutoff_value_and_slope_core_tb;
  import ccvs_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [SLOPE_W-1:0]  slope;
  } cutoff_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DIST_W-1:0]     s_tdata = '0;      // [23:0] distance
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;           // [16:0] weight, [42:17] slope
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  // Shadow copy of the block's registers
  logic [CFG_W-1:0] cutoff_reg  = CUTOFF_RST;
  logic [CFG_W-1:0] width_reg   = WIDTH_RST;
  logic [CFG_W-1:0] inverse_reg = INVERSE_RST;

  logic [DIST_W-1:0] distance_q[$];
  cutoff_result_t    weight_slope_q[$];
  cutoff_result_t    want_result;
  int                mismatch_count = 0;
  logic              no_idle = 1'b0;
  int                hold_trig = 0;
  int                hold_ack = 0;
  int                hold_left = 0;

  cosine_cutoff_value_and_slope_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Weight and slope of the cosine cutoff for one distance
  function automatic cutoff_result_t cutoff_weight_slope(input logic [DIST_W-1:0] distance,
                                                         input logic [CFG_W-1:0] cut,
                                                         input logic [CFG_W-1:0] width,
                                                         input logic [CFG_W-1:0] inv);
    longint                  r, inner, ss, cs, sn, cn, sv;
    longint unsigned         d, p, q, f, x, x2, ts, tc, dv, pi_inv, s24, m;
    int                      term;
    cutoff_result_t          res;
    r = distance;
    inner = longint'(cut) - longint'(width);
    if (r <= inner) begin
      res.weight = WEIGHT_W'(1) << OUT_FRAC_BITS;
      res.slope = '0;
    end else if (r >= longint'(cut)) begin
      res.weight = '0;
      res.slope = '0;
    end else begin
      // Phase in half turns, rounded to ANGLE_BITS fraction bits, one full turn wraps
      d = unsigned'(r - inner);
      p = d * inv;
      p = ((p + (64'd1 << (33 - ANGLE_BITS))) >> (34 - ANGLE_BITS))
          & ((64'd1 << (ANGLE_BITS + 1)) - 1);
      q = (p >> (ANGLE_BITS - 1)) & 64'd3;
      f = p & ((64'd1 << (ANGLE_BITS - 1)) - 1);
      x = f * PI_Q30;
      x = x >> ANGLE_BITS;

      // Taylor series for sine and cosine within one quadrant
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      ss = 0;
      cs = 0;
      for (term = 0; term < N_TERMS; term++) begin
        if (term % 2 == 1) begin
          ss = ss - signed'(ts);
          cs = cs - signed'(tc);
        end else begin
          ss = ss + signed'(ts);
          cs = cs + signed'(tc);
        end
        dv = 64'((2 * term + 2) * (2 * term + 3));
        ts = ((ts * x2) >> 30) / dv;
        dv = 64'((2 * term + 1) * (2 * term + 2));
        tc = ((tc * x2) >> 30) / dv;
      end
      if (ss > (64'sd1 << 30)) ss = 64'sd1 << 30;
      if (ss < -(64'sd1 << 30)) ss = -(64'sd1 << 30);
      if (cs > (64'sd1 << 30)) cs = 64'sd1 << 30;
      if (cs < -(64'sd1 << 30)) cs = -(64'sd1 << 30);

      // Rotate by quadrant
      case (q)
        64'd0: begin sn = ss;  cn = cs;  end
        64'd1: begin sn = cs;  cn = -ss; end
        64'd2: begin sn = -ss; cn = -cs; end
        default: begin sn = -cs; cn = ss; end
      endcase

      m = unsigned'(cn + (64'sd1 << 30)) + (64'd1 << (30 - OUT_FRAC_BITS));
      m = m >> (31 - OUT_FRAC_BITS);
      res.weight = m[WEIGHT_W-1:0];

      // Slope magnitude is pi * inverse width * |sin| / 2, sign opposite to sin
      pi_inv = inv;
      pi_inv = (pi_inv * PI_Q30) >> 16;
      s24 = unsigned'(sn < 0 ? -sn : sn);
      s24 = (s24 + 64'd32) >> 6;
      m = (pi_inv * s24 + (64'd1 << (54 - OUT_FRAC_BITS))) >> (55 - OUT_FRAC_BITS);
      if (m > (64'd1 << (SLOPE_W - 1))) m = 64'd1 << (SLOPE_W - 1);
      sv = (sn < 0) ? signed'(m) : -signed'(m);
      if (sv > (64'sd1 << (SLOPE_W - 1)) - 1) sv = (64'sd1 << (SLOPE_W - 1)) - 1;
      if (sv < -(64'sd1 << (SLOPE_W - 1))) sv = -(64'sd1 << (SLOPE_W - 1));
      res.slope = sv[SLOPE_W-1:0];
    end
    return res;
  endfunction

  // Random distance: mostly in the band, some at its edges, some anywhere
  function automatic logic [DIST_W-1:0] pick_distance();
    longint inner, lo, hi, v;
    int     sel;
    inner = longint'(cutoff_reg) - longint'(width_reg);
    lo = (inner + 1 < 0) ? 0 : inner + 1;
    hi = longint'(cutoff_reg) - 1;
    sel = $urandom_range(99);
    if (sel < 65 && lo <= hi) begin
      v = $urandom_range(int'(hi), int'(lo));
    end else if (sel < 82) begin
      v = ((sel % 2 == 1) ? inner : longint'(cutoff_reg)) + longint'($urandom_range(6)) - 3;
      if (v < 0) v = 0;
      if (v > 64'hFF_FFFF) v = 64'hFF_FFFF;
    end else begin
      v = $urandom & 32'hFF_FFFF;
    end
    return v[DIST_W-1:0];
  endfunction

  task automatic push_distances(input int n);
    repeat (n) distance_q.push_back(pick_distance());
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 30) $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CUTOFF: cutoff_reg = val;
      CFG_WIDTH: width_reg = val;
      CFG_INVERSE: inverse_reg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_W-1:0] cut, input logic [CFG_W-1:0] width,
                           input logic [CFG_W-1:0] inv);
    write_reg(CFG_CUTOFF, cut);
    write_reg(CFG_WIDTH, width);
    write_reg(CFG_INVERSE, inv);
  endtask

  // Hold until every queued distance is sent and every result is back
  task automatic wait_drain();
    while (distance_q.size() != 0 || s_tvalid || weight_slope_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sender: offer queued distances, predict each transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        weight_slope_q.push_back(cutoff_weight_slope(s_tdata, cutoff_reg, width_reg,
                                                     inverse_reg));
      if (!s_tvalid || s_tready) begin
        if (distance_q.size() != 0 && (no_idle || $urandom_range(99) >= 22)) begin
          s_tvalid <= 1'b1;
          s_tdata <= distance_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random backpressure plus requested long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_trig != hold_ack) begin
      hold_ack <= hold_trig;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_idle || ($urandom_range(99) >= 22);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (weight_slope_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, tdata=%h", m_tdata));
      end else begin
        want_result = weight_slope_q.pop_front();
        if (m_tdata[WEIGHT_W-1:0] !== want_result.weight)
          report_mismatch($sformatf("weight got %0d want %0d",
                                    m_tdata[WEIGHT_W-1:0], want_result.weight));
        if (m_tdata[WEIGHT_W+SLOPE_W-1:WEIGHT_W] !== want_result.slope)
          report_mismatch($sformatf("slope got %h want %h",
                                    m_tdata[WEIGHT_W+SLOPE_W-1:WEIGHT_W], want_result.slope));
      end
    end
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] cut, width, inv;
    longint unsigned  ratio;
    int               ph;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: field extremes, band edges, inner and random points, drained
    distance_q.push_back('0);
    distance_q.push_back('1);
    distance_q.push_back(cutoff_reg - width_reg - 1);
    distance_q.push_back(cutoff_reg - width_reg);
    distance_q.push_back(cutoff_reg - width_reg + 1);
    distance_q.push_back(cutoff_reg - width_reg / 4);
    distance_q.push_back(cutoff_reg - width_reg / 2);
    distance_q.push_back(cutoff_reg - 3 * (width_reg / 4));
    distance_q.push_back(cutoff_reg - 1);
    distance_q.push_back(cutoff_reg);
    distance_q.push_back(cutoff_reg + 1);
    push_distances(75);
    wait_drain();
    push_distances(75);
    wait_drain();

    // All registers at maximum: phase wraps; receiver holds off
    configure('1, '1, '1);
    distance_q.push_back('0);
    distance_q.push_back(24'd1);
    distance_q.push_back(24'hFF_FFFE);
    distance_q.push_back('1);
    push_distances(150);
    @(posedge clk);
    hold_trig <= hold_trig + 1;
    wait_drain();

    // Zero width and zero inverse: distance at the cutoff counts as inside
    configure(24'h14_0000, '0, '0);
    distance_q.push_back(24'h13_FFFF);
    distance_q.push_back(24'h14_0000);
    distance_q.push_back(24'h14_0001);
    push_distances(100);
    wait_drain();

    // Width above cutoff: nothing is inside
    configure(24'h10_0000, 24'h30_0000, 24'd5461);
    distance_q.push_back('0);
    distance_q.push_back(24'd1);
    push_distances(150);
    wait_drain();

    // Inverse width zero inside a normal band, with no idling on either side
    configure(CUTOFF_RST, WIDTH_RST, '0);
    @(posedge clk);
    no_idle <= 1'b1;
    distance_q.push_back(CUTOFF_RST - WIDTH_RST / 2);
    push_distances(100);
    wait_drain();
    no_idle <= 1'b0;

    // All registers at zero
    configure('0, '0, '0);
    push_distances(50);
    wait_drain();

    // Random settings, mostly with the matching inverse
    for (ph = 0; ph < 5; ph++) begin
      width = ($urandom_range(1) == 1) ? $urandom_range(24'hFF_FFFF, 1024)
                                       : $urandom_range(24'h10_0000, 1024);
      cut = $urandom & 32'hFF_FFFF;
      ratio = (64'd1 << 34) / width;
      if (ratio > 64'hFF_FFFF) ratio = 64'hFF_FFFF;
      inv = ($urandom_range(3) == 0) ? ($urandom & 32'hFF_FFFF) : ratio[CFG_W-1:0];
      configure(cut, width, inv);
      push_distances(120);
      wait_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (weight_slope_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", weight_slope_q.size()));
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> cosine_cutoff_value_and_slope_core.f
rtl/ccvs_pkg.sv
rtl/ccvs_front.sv
rtl/ccvs_cell.sv
rtl/ccvs_back.sv
rtl/cosine_cutoff_value_and_slope_core.sv
verif/cosine_cutoff_value_and_slope_core_tb.sv
